// ===== rtl/tcq_pkg.sv =====
// ----------------------------------------------------------------------------
// Two-class oldest-first queue package
// Request and result types and the operation and status codes.
// ----------------------------------------------------------------------------
package tcq_pkg;

  localparam int FIELD_W = 16;

  typedef enum logic [1:0] {
    MODE_ENQ     = 2'd0,
    MODE_DEQ_ANY = 2'd1,
    MODE_DEQ_A   = 2'd2,
    MODE_DEQ_B   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_ENQUEUED = 2'd0,
    ST_DEQUEUED = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  localparam logic CLASS_A = 1'b0;
  localparam logic CLASS_B = 1'b1;

  typedef struct packed {
    mode_t               mode;
    logic                item_class;
    logic [FIELD_W-1:0]  item_tag;
  } in_t;

  typedef struct packed {
    status_t             status;
    logic                out_class;
    logic [FIELD_W-1:0]  out_tag;
    logic [FIELD_W-1:0]  out_stamp;
  } out_t;

endpackage

// ===== rtl/tcq_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tcq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/tcq_fifo.sv =====
// ----------------------------------------------------------------------------
// Class FIFO
// Circular buffer in a RAM with the head entry prefetched so that it is
// visible in the same cycle that a request decides on it.
// ----------------------------------------------------------------------------
module tcq_fifo #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head_data,
  output logic             empty,
  output logic             full
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [PW-1:0]    head_r, head_nxt;
  logic [PW-1:0]    tail_r, tail_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             byp_r;
  logic [WIDTH-1:0] byp_data_r;
  logic [WIDTH-1:0] ram_rdata;

  function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    head_nxt  = pop  ? next_ptr(head_r) : head_r;
    tail_nxt  = push ? next_ptr(tail_r) : tail_r;
    count_nxt = count_r + CW'(push) - CW'(pop);
  end

  tcq_ram #(
    .WIDTH(WIDTH),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (push),
    .waddr(tail_r),
    .wdata(push_data),
    .raddr(head_nxt),
    .rdata(ram_rdata)
  );

  // A write to the entry being prefetched is forwarded around the RAM.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
      byp_r   <= 1'b0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      byp_r   <= push && (tail_r == head_nxt);
    end
    byp_data_r <= push_data;
  end

  assign head_data = byp_r ? byp_data_r : ram_rdata;
  assign empty     = (count_r == '0);
  assign full      = (count_r == CW'(DEPTH));

endmodule

// ===== rtl/two_class_oldest_first_queue.sv =====
// ----------------------------------------------------------------------------
// Two-class oldest-first queue
// Output: the result of an accepted request is in the output register in the next cycle.
// Throughput: one request per cycle unless out_stall holds a valid result; the FIFO
// head entries are prefetched from their RAMs so each request is decided in a single pass.
// Reset: rst_n clears pointers, counts, the arrival counter and the output valid.
// ----------------------------------------------------------------------------
module two_class_oldest_first_queue #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TAG_WIDTH   = 16,
  parameter int STAMP_WIDTH = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  tcq_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output tcq_pkg::out_t out_data
);

  import tcq_pkg::*;

  localparam int EW     = TAG_WIDTH + STAMP_WIDTH;
  localparam int TAG_IN = (TAG_WIDTH < FIELD_W) ? TAG_WIDTH : FIELD_W;
  localparam int STP_IN = (STAMP_WIDTH < FIELD_W) ? STAMP_WIDTH : FIELD_W;

  logic                   accept;
  logic [STAMP_WIDTH-1:0] arrival_r, arrival_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_t                   out_data_r;
  out_t                   res;
  logic                   push_a, push_b, pop_a, pop_b;
  logic                   take_a, take_b;
  logic [EW-1:0]          push_data;
  logic [EW-1:0]          head_a, head_b, head_sel;
  logic                   empty_a, empty_b, full_a, full_b;
  logic [STAMP_WIDTH-1:0] stamp_diff;
  logic                   a_older;
  logic                   tgt_full;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  assign push_data = {TAG_WIDTH'(in_data.item_tag[TAG_IN-1:0]), arrival_r};

  assign stamp_diff = head_a[STAMP_WIDTH-1:0] - head_b[STAMP_WIDTH-1:0];
  assign a_older    = stamp_diff[STAMP_WIDTH-1];
  assign tgt_full   = (in_data.item_class == CLASS_B) ? full_b : full_a;

  always_comb begin
    take_a = 1'b0;
    take_b = 1'b0;
    case (in_data.mode)
      MODE_DEQ_A: begin
        take_a = !empty_a;
      end
      MODE_DEQ_B: begin
        take_b = !empty_b;
      end
      MODE_DEQ_ANY: begin
        if (empty_a) begin
          take_b = !empty_b;
        end else if (empty_b) begin
          take_a = 1'b1;
        end else begin
          take_a = a_older;
          take_b = !a_older;
        end
      end
      default: begin
        take_a = 1'b0;
        take_b = 1'b0;
      end
    endcase
  end

  assign head_sel = take_b ? head_b : head_a;

  always_comb begin
    res           = '0;
    res.status    = ST_EMPTY;
    push_a        = 1'b0;
    push_b        = 1'b0;
    arrival_nxt   = arrival_r;
    if (in_data.mode == MODE_ENQ) begin
      res.out_class = in_data.item_class;
      if (tgt_full) begin
        res.status = ST_FULL;
      end else begin
        res.status    = ST_ENQUEUED;
        res.out_stamp = FIELD_W'(arrival_r[STP_IN-1:0]);
        push_a        = accept && (in_data.item_class == CLASS_A);
        push_b        = accept && (in_data.item_class == CLASS_B);
        if (accept) begin
          arrival_nxt = arrival_r + 1'b1;
        end
      end
    end else if (take_a || take_b) begin
      res.status    = ST_DEQUEUED;
      res.out_class = take_b ? CLASS_B : CLASS_A;
      res.out_tag   = FIELD_W'(head_sel[STAMP_WIDTH +: TAG_IN]);
      res.out_stamp = FIELD_W'(head_sel[STP_IN-1:0]);
    end
  end

  assign pop_a = accept && take_a;
  assign pop_b = accept && take_b;

  tcq_fifo #(
    .WIDTH(EW),
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo_a (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push_a),
    .push_data(push_data),
    .pop      (pop_a),
    .head_data(head_a),
    .empty    (empty_a),
    .full     (full_a)
  );

  tcq_fifo #(
    .WIDTH(EW),
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo_b (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push_b),
    .push_data(push_data),
    .pop      (pop_b),
    .head_data(head_b),
    .empty    (empty_b),
    .full     (full_b)
  );

  assign out_valid_nxt = accept || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arrival_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      arrival_r   <= arrival_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (accept) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
